// ===== rtl/itra_pkg.sv =====
// Shared constants, types and character helpers for the integer to radix ASCII core.
// Depends on nothing; every other file of the core imports it.
`default_nettype none

package itra_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int KIND_WIDTH = 2;
   localparam int CHAR_WIDTH = 8;

   // divider takes this many dividend bits per cycle
   localparam int STEP_BITS = 4;
   localparam int STEP_COUNT = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_WIDTH = STEP_COUNT * STEP_BITS;
   localparam int POS_WIDTH = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

   // radix 2 of the most negative value gives VALUE_WIDTH digits
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int DIGIT_IDX_WIDTH = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_COUNT_WIDTH = $clog2(DIGIT_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(36);

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'd120;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_B = 8'd98;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOLLAR = 8'd36;
   // 'a' minus ten
   localparam logic [CHAR_WIDTH-1:0] CHAR_LETTER_BASE = 8'd87;

   typedef enum logic [KIND_WIDTH-1:0] {
      PREFIX_NONE   = 2'd0,
      PREFIX_HEX    = 2'd1,
      PREFIX_BIN    = 2'd2,
      PREFIX_DOLLAR = 2'd3
   } prefix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_PREFIX_A,
      ST_PREFIX_B,
      ST_DIGITS
   } back_state_type;

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [RADIX_WIDTH-1:0] radix;
      prefix_type             prefix;
   } job_type;

   // digit value to 0-9a-z
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [RADIX_WIDTH-1:0] dc;
      dc = (d > RADIX_WIDTH'(35)) ? RADIX_WIDTH'(35) : d;
      if (dc < RADIX_WIDTH'(10)) begin
         return CHAR_ZERO + CHAR_WIDTH'(dc);
      end
      return CHAR_LETTER_BASE + CHAR_WIDTH'(dc);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/itra_front.sv =====
// Front end: takes a request, forms the magnitude, clamps the radix, tags the prefix.
// Depends on itra_pkg.
`default_nettype none

module itra_front
   import itra_pkg::*;
(
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic [RADIX_WIDTH-1:0]        req_radix,
   input  wire logic [KIND_WIDTH-1:0]         req_prefix_kind,
   input  wire logic                          q_full,
   output logic                               q_push,
   output job_type                            q_job
);

   logic                   neg;
   logic [VALUE_WIDTH-1:0] raw;

   always_comb begin
      raw = req_value;
      neg = raw[VALUE_WIDTH-1];
      q_job.negative = neg;
      // most negative value wraps to its true unsigned magnitude
      q_job.magnitude = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
      if (req_radix < RADIX_MIN) begin
         q_job.radix = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         q_job.radix = RADIX_MAX;
      end else begin
         q_job.radix = req_radix;
      end
      q_job.prefix = prefix_type'(req_prefix_kind);
      req_full = q_full;
      q_push = req_push & ~q_full;
   end

endmodule

`default_nettype wire

// ===== rtl/itra_queue.sv =====
// Short job queue between the front end and the converter.
// Depends on itra_pkg.
`default_nettype none

module itra_queue
   import itra_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   output logic      full,
   input  wire logic pop,
   output logic      valid,
   output job_type   head_job
);

   job_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   always_comb begin
      full = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
      valid = (count_ff != '0);
      head_job = entry_ff[rd_ptr_ff];
      do_push = push & ~full;
      do_pop = pop & valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/itra_back.sv =====
// Back end: iterative radix divider, digit stack and character sequencer with output register.
// Depends on itra_pkg.
`default_nettype none

module itra_back
   import itra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  job_type                 q_job,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [CHAR_WIDTH-1:0]   rsp_ascii_char,
   output logic                    rsp_last
);

   back_state_type               state_ff, state_in;
   logic [PAD_WIDTH-1:0]         num_ff, num_in;
   logic [POS_WIDTH-1:0]         pos_ff, pos_in;
   logic [POS_WIDTH-1:0]         top_ff, top_in;
   logic                         found_ff, found_in;
   logic [RADIX_WIDTH-1:0]       rem_ff, rem_in;
   logic [DIGIT_COUNT_WIDTH-1:0] dcnt_ff, dcnt_in;
   logic                         neg_ff, neg_in;
   logic [RADIX_WIDTH-1:0]       radix_ff, radix_in;
   prefix_type                   prefix_ff, prefix_in;
   logic [RADIX_WIDTH-1:0]       digit_ff [DIGIT_DEPTH];
   logic                         out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0]        out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;

   logic                         slot_free;
   logic                         emit;
   logic [CHAR_WIDTH-1:0]        emit_char;
   logic                         emit_last;
   logic                         dig_we;
   logic [STEP_BITS-1:0]         nib;
   logic [STEP_BITS-1:0]         quo;
   logic [RADIX_WIDTH-1:0]       rem_new;
   logic [DIGIT_COUNT_WIDTH-1:0] dcnt_m1;

   // four restoring steps: remainder stays below the radix
   function automatic logic [STEP_BITS+RADIX_WIDTH-1:0] div_step(
      input logic [RADIX_WIDTH-1:0] rem,
      input logic [STEP_BITS-1:0]   bits,
      input logic [RADIX_WIDTH-1:0] radix
   );
      logic [RADIX_WIDTH:0]   acc;
      logic [RADIX_WIDTH-1:0] r;
      logic [STEP_BITS-1:0]   q;
      r = rem;
      q = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         acc = {r, bits[i]};
         if (acc >= {1'b0, radix}) begin
            q[i] = 1'b1;
            acc = acc - {1'b0, radix};
         end
         r = acc[RADIX_WIDTH-1:0];
      end
      return {q, r};
   endfunction

   function automatic back_state_type after_sign(input prefix_type p);
      case (p)
         PREFIX_HEX, PREFIX_BIN: return ST_PREFIX_A;
         PREFIX_DOLLAR:          return ST_PREFIX_B;
         default:                return ST_DIGITS;
      endcase
   endfunction

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      pos_in = pos_ff;
      top_in = top_ff;
      found_in = found_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      neg_in = neg_ff;
      radix_in = radix_ff;
      prefix_in = prefix_ff;
      q_pop = 1'b0;
      dig_we = 1'b0;
      emit = 1'b0;
      emit_char = CHAR_ZERO;
      emit_last = 1'b0;
      slot_free = ~out_valid_ff | rsp_pop;
      nib = num_ff[pos_ff*STEP_BITS +: STEP_BITS];
      {quo, rem_new} = div_step(rem_ff, nib, radix_ff);
      dcnt_m1 = dcnt_ff - DIGIT_COUNT_WIDTH'(1);

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               neg_in = q_job.negative;
               radix_in = q_job.radix;
               prefix_in = q_job.prefix;
               num_in = PAD_WIDTH'(q_job.magnitude);
               pos_in = POS_WIDTH'(STEP_COUNT - 1);
               top_in = '0;
               found_in = 1'b0;
               rem_in = '0;
               dcnt_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // quotient group replaces the dividend group in place
            num_in[pos_ff*STEP_BITS +: STEP_BITS] = quo;
            rem_in = rem_new;
            if (quo != '0 && !found_ff) begin
               found_in = 1'b1;
               top_in = pos_ff;
            end
            if (pos_ff == '0) begin
               dig_we = 1'b1;
               dcnt_in = dcnt_ff + DIGIT_COUNT_WIDTH'(1);
               rem_in = '0;
               found_in = 1'b0;
               if (!found_ff && quo == '0) begin
                  state_in = neg_ff ? ST_SIGN : after_sign(prefix_ff);
               end else begin
                  // restart at the highest non-zero quotient group
                  pos_in = found_ff ? top_ff : pos_ff;
               end
            end else begin
               pos_in = pos_ff - POS_WIDTH'(1);
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_char = CHAR_MINUS;
               state_in = after_sign(prefix_ff);
            end
         end
         ST_PREFIX_A: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_char = CHAR_ZERO;
               state_in = ST_PREFIX_B;
            end
         end
         ST_PREFIX_B: begin
            if (slot_free) begin
               emit = 1'b1;
               case (prefix_ff)
                  PREFIX_HEX: emit_char = CHAR_LOWER_X;
                  PREFIX_BIN: emit_char = CHAR_LOWER_B;
                  default:    emit_char = CHAR_DOLLAR;
               endcase
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_char = digit_char(digit_ff[dcnt_m1[DIGIT_IDX_WIDTH-1:0]]);
               emit_last = (dcnt_ff == DIGIT_COUNT_WIDTH'(1));
               dcnt_in = dcnt_m1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff & ~rsp_pop;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in = emit_char;
         out_last_in = emit_last;
      end

      rsp_empty = ~out_valid_ff;
      rsp_ascii_char = out_char_ff;
      rsp_last = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         found_ff <= found_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      pos_ff <= pos_in;
      top_ff <= top_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      radix_ff <= radix_in;
      prefix_ff <= prefix_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (dig_we) begin
         digit_ff[dcnt_ff[DIGIT_IDX_WIDTH-1:0]] <= rem_new;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/integer_to_radix_ascii_core.sv =====
// Integer to radix ASCII core: a signed number becomes a stream of characters,
// '-' when negative, then an optional "0x", "0b" or "$" prefix, then the digits of the
// magnitude in radix 2 to 36 (0-9a-z), most significant first, with the final character
// flagged by rsp_last. The most negative value prints its full magnitude, zero prints
// one '0', radix 0 and 1 act as 2 and radix above 36 acts as 36. Requests enter through a
// queue-like port (push, full) into a two-deep job queue, so a further number is taken
// while one is being converted; results leave through an output register (empty, pop).
// Per number: the job is loaded, then the divider consumes four bits of the running
// quotient per cycle and restarts each digit at the highest non-zero four-bit group,
// then the characters leave one per cycle while the output register is free or popped.
// A stalled pop holds the character sequencer but not the front queue. Reset is
// synchronous and active high.
// Depends on itra_pkg, itra_front, itra_queue and itra_back.
`default_nettype none

module integer_to_radix_ascii_core
   import itra_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic [RADIX_WIDTH-1:0]        req_radix,
   input  wire logic [KIND_WIDTH-1:0]         req_prefix_kind,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [CHAR_WIDTH-1:0]              rsp_ascii_char,
   output logic                               rsp_last
);

   job_type front_job;
   job_type head_job;
   logic    q_push;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;

   // classify the request: sign, magnitude, clamped radix, prefix
   itra_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_radix       (req_radix),
      .req_prefix_kind (req_prefix_kind),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (front_job)
   );

   // hold up to two jobs so the front keeps taking requests during a conversion
   itra_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_job (head_job)
   );

   // divide into digits, then advance through sign, prefix and digits
   itra_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (head_job),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/itra_checker.sv =====
// Port-level checks for the integer to radix ASCII core, bound to the top level.
// Depends on itra_pkg and integer_to_radix_ascii_core.
`default_nettype none

module itra_checker
   import itra_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire logic [CHAR_WIDTH-1:0] rsp_ascii_char,
   input wire logic                  rsp_last
);

   // nothing to deliver straight after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_ascii_char) && $stable(rsp_last)))
      else $error("waiting result changed");

   // a minus sign always has digits after it
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_ascii_char == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged last");

   // the final character of a number is a digit
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |->
         ((rsp_ascii_char >= 8'd48 && rsp_ascii_char <= 8'd57) ||
          (rsp_ascii_char >= 8'd97 && rsp_ascii_char <= 8'd122)))
      else $error("last character is not a digit");

   // a character after a popped minus sign is never another minus sign
   a_single_minus: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_ascii_char == CHAR_MINUS) |=>
         (rsp_empty || rsp_ascii_char != CHAR_MINUS))
      else $error("two minus signs in a row");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for integer_to_radix_ascii_core: directed and random numbers
// pushed through the request queue, characters checked against an in-bench predictor.
// Depends on itra_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
   import itra_pkg::*;

   // worst case: radix 2, full magnitude, every character waiting out a pop stall
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 400;
   localparam int IDLE_PERCENT = 29;
   localparam int RANDOM_ROUND = 69;
   localparam logic [CHAR_WIDTH-1:0] LETTER_A = "a";

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [RADIX_WIDTH-1:0]        radix;
      logic [KIND_WIDTH-1:0]         kind;
   } number_req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } char_exp_type;

   logic                          clock;
   logic                          reset;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic [RADIX_WIDTH-1:0]        req_radix = '0;
   logic [KIND_WIDTH-1:0]         req_prefix_kind = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [CHAR_WIDTH-1:0]         rsp_ascii_char;
   logic                          rsp_last;

   number_req_type pending_numbers[$];
   char_exp_type   expected_chars[$];
   int             mismatches = 0;
   int             numbers_taken = 0;
   int             cycle_count = 0;
   bit             request_taken = 1'b0;
   bit             steady = 1'b0;

   integer_to_radix_ascii_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_radix       (req_radix),
      .req_prefix_kind (req_prefix_kind),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void add_char(input logic [CHAR_WIDTH-1:0] ch, input logic last);
      char_exp_type e;
      e.ch = ch;
      e.last = last;
      expected_chars.push_back(e);
   endfunction

   // Append the characters one number should produce: sign, prefix, then digits.
   function automatic void render_number(input number_req_type r);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] base;
      logic                   negative;
      logic [RADIX_WIDTH-1:0] digs [VALUE_WIDTH];
      logic [RADIX_WIDTH-1:0] d;
      int                     nd;
      base = VALUE_WIDTH'(r.radix);
      if (base < 2) base = 2;
      if (base > 36) base = 36;
      negative = r.value[VALUE_WIDTH-1];
      // two's complement negate; the most negative value keeps its full magnitude
      mag = negative ? (~r.value + 1'b1) : r.value;
      nd = 0;
      do begin
         digs[nd] = RADIX_WIDTH'(mag % base);
         nd++;
         mag = mag / base;
      end while (mag != 0);
      if (negative) add_char(CHAR_MINUS, 1'b0);
      case (r.kind)
         PREFIX_HEX: begin
            add_char(CHAR_ZERO, 1'b0);
            add_char(CHAR_LOWER_X, 1'b0);
         end
         PREFIX_BIN: begin
            add_char(CHAR_ZERO, 1'b0);
            add_char(CHAR_LOWER_B, 1'b0);
         end
         PREFIX_DOLLAR: add_char(CHAR_DOLLAR, 1'b0);
         default: ;
      endcase
      for (int i = nd - 1; i >= 0; i--) begin
         d = digs[i];
         if (d < 10) add_char(CHAR_ZERO + CHAR_WIDTH'(d), i == 0);
         else add_char(LETTER_A + CHAR_WIDTH'(d - 10), i == 0);
      end
   endfunction

   function automatic number_req_type make_number(input logic signed [VALUE_WIDTH-1:0] v,
                                                  input int radix, input prefix_type kind);
      number_req_type r;
      r.value = v;
      r.radix = RADIX_WIDTH'(radix);
      r.kind = kind;
      return r;
   endfunction

   // Random number: mostly legal radices, with a few out of range at either end.
   function automatic number_req_type random_number();
      number_req_type r;
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: begin
            v = $urandom_range(0, 1000);
            if ($urandom_range(0, 1)) v = -v;
         end
         7: v = $urandom_range(0, 1) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         default: begin
            v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      r.value = v;
      if ($urandom_range(0, 9) == 0) r.radix = RADIX_WIDTH'($urandom_range(0, 63));
      else r.radix = RADIX_WIDTH'($urandom_range(2, 36));
      r.kind = KIND_WIDTH'($urandom_range(0, 3));
      return r;
   endfunction

   // Accept side of the request channel: predict at the edge the request is taken.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL integer_to_radix_ascii_core");
         $finish;
      end
      if (!reset && req_push && !req_full) begin
         render_number('{value: req_value, radix: req_radix, kind: req_prefix_kind});
         request_taken = 1'b1;
         numbers_taken++;
         // no idling on either side for a stretch in the middle of the random part
         steady = (numbers_taken >= 90 && numbers_taken < 140);
      end
   end

   // Driver: hold a request until taken, then advance to the next or idle at random.
   always @(negedge clock) begin
      number_req_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || request_taken) begin
         request_taken = 1'b0;
         if (pending_numbers.size() > 0 &&
             (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            nxt = pending_numbers.pop_front();
            req_value <= nxt.value;
            req_radix <= nxt.radix;
            req_prefix_kind <= nxt.kind;
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: compare each popped character with the oldest expectation.
   always @(posedge clock) begin
      char_exp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character expected none actual char=%02h last=%0b",
                     $time, rsp_ascii_char, rsp_last);
            mismatches++;
         end else begin
            e = expected_chars.pop_front();
            if (rsp_ascii_char !== e.ch) begin
               $display("%0t: ascii_char mismatch expected %02h actual %02h",
                        $time, e.ch, rsp_ascii_char);
               mismatches++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last mismatch expected %0b actual %0b",
                        $time, e.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic wait_all_taken();
      while (pending_numbers.size() != 0 || req_push) @(posedge clock);
   endtask

   task automatic wait_all_chars();
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      // directed part: extremes of value and radix, every prefix, zero, clamped radices
      pending_numbers.push_back(make_number(0, 10, PREFIX_NONE));
      pending_numbers.push_back(make_number(0, 16, PREFIX_HEX));
      pending_numbers.push_back(make_number(-1, 10, PREFIX_NONE));
      pending_numbers.push_back(make_number(32'sh8000_0000, 10, PREFIX_NONE));
      pending_numbers.push_back(make_number(32'sh8000_0000, 2, PREFIX_BIN));
      pending_numbers.push_back(make_number(32'sh8000_0000, 16, PREFIX_HEX));
      pending_numbers.push_back(make_number(32'sh8000_0000, 36, PREFIX_DOLLAR));
      pending_numbers.push_back(make_number(32'sh7fff_ffff, 2, PREFIX_NONE));
      pending_numbers.push_back(make_number(32'sh7fff_ffff, 36, PREFIX_HEX));
      pending_numbers.push_back(make_number(32'sh7fff_ffff, 10, PREFIX_DOLLAR));
      pending_numbers.push_back(make_number(-255, 16, PREFIX_HEX));
      pending_numbers.push_back(make_number(-5, 2, PREFIX_BIN));
      pending_numbers.push_back(make_number(-42, 10, PREFIX_DOLLAR));
      pending_numbers.push_back(make_number(35, 36, PREFIX_NONE));
      pending_numbers.push_back(make_number(10, 11, PREFIX_NONE));
      pending_numbers.push_back(make_number(1, 2, PREFIX_NONE));
      pending_numbers.push_back(make_number(13, 0, PREFIX_NONE));
      pending_numbers.push_back(make_number(-13, 1, PREFIX_BIN));
      pending_numbers.push_back(make_number(1295, 37, PREFIX_NONE));
      pending_numbers.push_back(make_number(-1296, 63, PREFIX_DOLLAR));
      pending_numbers.push_back(make_number(0, 63, PREFIX_DOLLAR));
      pending_numbers.push_back(make_number(0, 0, PREFIX_BIN));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain completely before the random part: the sender holds off meanwhile
      wait_all_taken();
      wait_all_chars();
      for (int i = 0; i < RANDOM_ROUND; i++) pending_numbers.push_back(random_number());
      wait_all_taken();
      wait_all_chars();
      for (int i = 0; i < RANDOM_ROUND; i++) pending_numbers.push_back(random_number());
      wait_all_taken();
      wait_all_chars();

      // let any stray characters surface before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("PASS integer_to_radix_ascii_core");
      end else begin
         $display("FAIL integer_to_radix_ascii_core");
      end
      $finish;
   end

endmodule
